// ----- src/gf2inv_pkg.sv -----
// Shared constants, command/status structs and helpers for the GF(2) matrix inverter.
package gf2inv_pkg;

  localparam int MAX_SIZE = 16;
  localparam int ROW_W    = 16;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int CNT_W    = $clog2(MAX_SIZE + 1);
  localparam int CFG_W    = 5;

  // Controller to datapath
  typedef struct packed {
    logic [IDX_W-1:0] idx;        // row address for every access this cycle
    logic [IDX_W-1:0] col;        // pivot column
    logic [CNT_W-1:0] size;       // effective matrix size
    logic             load_row;
    logic             piv_load;
    logic             below_step;
    logic             piv_write;
    logic             above_step;
    logic             emit_row;
    logic             emit_sing;
    logic             emit_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic piv_bit;   // pivot register has the pivot column set
    logic out_busy;  // output register holds a beat that is stalled
  } status_t;

  function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] s);
    logic [CNT_W-1:0] r;
    r = CNT_W'(s);
    if (s == '0) begin
      r = CNT_W'(1);
    end else if (CFG_W'(s) > CFG_W'(MAX_SIZE)) begin
      r = CNT_W'(MAX_SIZE);
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] col_mask(input logic [CNT_W-1:0] n);
    logic [ROW_W:0] m;
    m = (ROW_W + 1)'(1) << n;
    return ROW_W'(m - (ROW_W + 1)'(1));
  endfunction

endpackage

// ----- src/gf2inv_dp.sv -----
// Datapath: row stores, pivot register, row update logic and output register.
module gf2inv_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  gf2inv_pkg::cmd_t               cmd,
  output gf2inv_pkg::status_t            sts,
  input  logic [gf2inv_pkg::ROW_W-1:0]   row_bits,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gf2inv_pkg::ROW_W-1:0]   inverse_row,
  output logic                           singular,
  output logic                           last_row
);

  logic [gf2inv_pkg::ROW_W-1:0] work_rows [gf2inv_pkg::MAX_SIZE];
  logic [gf2inv_pkg::ROW_W-1:0] inv_rows  [gf2inv_pkg::MAX_SIZE];
  logic [gf2inv_pkg::ROW_W-1:0] piv_w;
  logic [gf2inv_pkg::ROW_W-1:0] piv_v;
  logic [gf2inv_pkg::ROW_W-1:0] rd_w;
  logic [gf2inv_pkg::ROW_W-1:0] rd_v;
  logic                         rd_bit;
  logic                         piv_bit;

  assign rd_w    = work_rows[cmd.idx];
  assign rd_v    = inv_rows[cmd.idx];
  assign rd_bit  = rd_w[cmd.col];
  assign piv_bit = piv_w[cmd.col];

  assign sts.piv_bit  = piv_bit;
  assign sts.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      work_rows[cmd.idx] <= row_bits & gf2inv_pkg::col_mask(cmd.size);
      inv_rows[cmd.idx]  <= gf2inv_pkg::ROW_W'(1) << cmd.idx;
    end else if (cmd.piv_load) begin
      piv_w <= rd_w;
      piv_v <= rd_v;
    end else if (cmd.below_step) begin
      if (!piv_bit && rd_bit) begin
        // swap the lower row with the pivot row
        work_rows[cmd.idx] <= piv_w;
        inv_rows[cmd.idx]  <= piv_v;
        piv_w              <= rd_w;
        piv_v              <= rd_v;
      end else if (rd_bit) begin
        work_rows[cmd.idx] <= rd_w ^ piv_w;
        inv_rows[cmd.idx]  <= rd_v ^ piv_v;
      end
    end else if (cmd.piv_write) begin
      work_rows[cmd.idx] <= piv_w;
      inv_rows[cmd.idx]  <= piv_v;
    end else if (cmd.above_step) begin
      if (rd_bit) begin
        work_rows[cmd.idx] <= rd_w ^ piv_w;
        inv_rows[cmd.idx]  <= rd_v ^ piv_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_row || cmd.emit_sing) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_row) begin
      inverse_row <= rd_v;
      singular    <= 1'b0;
      last_row    <= cmd.emit_last;
    end else if (cmd.emit_sing) begin
      inverse_row <= '0;
      singular    <= 1'b1;
      last_row    <= 1'b1;
    end
  end

endmodule

// ----- src/gf2inv_ctrl.sv -----
// Controller: size register, load counter and elimination/emit sequencer.
module gf2inv_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gf2inv_pkg::CFG_W-1:0]   cfg_data,
  input  gf2inv_pkg::status_t            sts,
  output gf2inv_pkg::cmd_t               cmd
);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_PIV   = 7'b0000010,
    S_BELOW = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_ABOVE = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_SING  = 7'b1000000
  } state_t;

  state_t                         state, state_next;
  logic [gf2inv_pkg::CFG_W-1:0]   size_reg;
  logic [gf2inv_pkg::CNT_W-1:0]   rows_loaded, rows_loaded_next;
  logic [gf2inv_pkg::IDX_W-1:0]   piv, piv_next;
  logic [gf2inv_pkg::IDX_W-1:0]   row, row_next;
  logic [gf2inv_pkg::CNT_W-1:0]   n;
  logic [gf2inv_pkg::CNT_W-1:0]   piv_p1;
  logic [gf2inv_pkg::CNT_W-1:0]   row_p1;
  logic [gf2inv_pkg::CNT_W-1:0]   load_idx;
  logic                           in_beat;
  logic                           cfg_beat;

  assign n        = gf2inv_pkg::eff_size(size_reg);
  assign piv_p1   = gf2inv_pkg::CNT_W'(piv) + gf2inv_pkg::CNT_W'(1);
  assign row_p1   = gf2inv_pkg::CNT_W'(row) + gf2inv_pkg::CNT_W'(1);
  assign load_idx = (rows_loaded >= n) ? '0 : rows_loaded;

  // a pending size write holds off row beats so no row is taken and then dropped
  assign in_stall  = (state != S_LOAD) || cfg_valid;
  assign cfg_ready = (state == S_LOAD);
  assign in_beat   = in_valid && !in_stall;
  assign cfg_beat  = cfg_valid && cfg_ready;

  always_comb begin
    state_next       = state;
    rows_loaded_next = rows_loaded;
    piv_next         = piv;
    row_next         = row;
    cmd              = '0;
    cmd.col          = piv;
    cmd.size         = n;
    cmd.idx          = row;
    case (state)
      S_LOAD: begin
        cmd.idx      = load_idx[gf2inv_pkg::IDX_W-1:0];
        cmd.load_row = in_beat;
        if (cfg_beat) begin
          rows_loaded_next = '0;
        end else if (in_beat) begin
          if (load_idx + gf2inv_pkg::CNT_W'(1) == n) begin
            rows_loaded_next = '0;
            piv_next         = '0;
            state_next       = S_PIV;
          end else begin
            rows_loaded_next = load_idx + gf2inv_pkg::CNT_W'(1);
          end
        end
      end
      S_PIV: begin
        cmd.idx      = piv;
        cmd.piv_load = 1'b1;
        row_next     = piv_p1[gf2inv_pkg::IDX_W-1:0];
        state_next   = (piv_p1 == n) ? S_CHECK : S_BELOW;
      end
      S_BELOW: begin
        cmd.below_step = 1'b1;
        row_next       = row_p1[gf2inv_pkg::IDX_W-1:0];
        if (row_p1 == n) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.idx       = piv;
        cmd.piv_write = 1'b1;
        row_next      = '0;
        if (!sts.piv_bit) begin
          state_next = S_SING;
        end else if (piv != '0) begin
          state_next = S_ABOVE;
        end else if (piv_p1 == n) begin
          state_next = S_EMIT;
        end else begin
          piv_next   = piv_p1[gf2inv_pkg::IDX_W-1:0];
          state_next = S_PIV;
        end
      end
      S_ABOVE: begin
        cmd.above_step = 1'b1;
        row_next       = row_p1[gf2inv_pkg::IDX_W-1:0];
        if (row_p1[gf2inv_pkg::IDX_W-1:0] == piv) begin
          row_next = '0;
          if (piv_p1 == n) begin
            state_next = S_EMIT;
          end else begin
            piv_next   = piv_p1[gf2inv_pkg::IDX_W-1:0];
            state_next = S_PIV;
          end
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit_row  = 1'b1;
          cmd.emit_last = (row_p1 == n);
          row_next      = row_p1[gf2inv_pkg::IDX_W-1:0];
          if (row_p1 == n) begin
            state_next = S_LOAD;
          end
        end
      end
      S_SING: begin
        if (!sts.out_busy) begin
          cmd.emit_sing = 1'b1;
          state_next    = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      size_reg    <= gf2inv_pkg::CFG_W'(gf2inv_pkg::MAX_SIZE);
      rows_loaded <= '0;
      piv         <= '0;
      row         <= '0;
    end else begin
      state       <= state_next;
      rows_loaded <= rows_loaded_next;
      piv         <= piv_next;
      row         <= row_next;
      if (cfg_beat) begin
        size_reg <= cfg_data;
      end
    end
  end

endmodule

// ----- src/gf2_matrix_inverse_top.sv -----
// Top level: GF(2) Gauss-Jordan matrix inverter, controller plus datapath.
// Load: n row beats (n = effective size, 1..16), one per cycle while no size write waits.
// Elimination, per pivot column: pivot read, rows below, write-back, rows above;
// one row update per cycle on the row store port. Then n result beats (one if singular).
// Sync reset clears the sequencer, load count and output valid and sets size to 16.
module gf2_matrix_inverse_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gf2inv_pkg::ROW_W-1:0]   row_bits,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gf2inv_pkg::ROW_W-1:0]   inverse_row,
  output logic                           singular,
  output logic                           last_row,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gf2inv_pkg::CFG_W-1:0]   cfg_data
);

  gf2inv_pkg::cmd_t    cmd;
  gf2inv_pkg::status_t sts;

  gf2inv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd)
  );

  gf2inv_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .row_bits    (row_bits),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .inverse_row (inverse_row),
    .singular    (singular),
    .last_row    (last_row)
  );

endmodule

// ----- src/gf2inv_checker.sv -----
// Port-level checker for the GF(2) matrix inverter, bound to the top level.
module gf2inv_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [gf2inv_pkg::ROW_W-1:0]   row_bits,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [gf2inv_pkg::ROW_W-1:0]   inverse_row,
  input logic                           singular,
  input logic                           last_row,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [gf2inv_pkg::CFG_W-1:0]   cfg_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inverse_row) && $stable(singular)
      && $stable(last_row))
    else $error("result beat changed while stalled");

  // singular result is a single closing beat with a zero row
  a_sing_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> inverse_row == '0 && last_row)
    else $error("singular beat malformed");

  // rows and config are only taken in the load phase, rows only with no config pending
  a_cfg_load: assert property (@(posedge clk) disable iff (rst)
    !in_stall == (cfg_ready && !cfg_valid))
    else $error("config ready outside load phase");

  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gf2_matrix_inverse_top gf2inv_checker u_chk (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for the GF(2) Gauss-Jordan matrix inverter.
`timescale 1ns / 1ps

module tb;

  localparam int ROW_W    = gf2inv_pkg::ROW_W;
  localparam int CFG_W    = gf2inv_pkg::CFG_W;
  localparam int MAX_SIZE = gf2inv_pkg::MAX_SIZE;

  localparam int SETTLE_CYCLES = 320;  // one full 16x16 inversion plus margin
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ROWS   = 380;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             sing;
    logic             last;
  } inv_beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ROW_W-1:0] row_bits = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ROW_W-1:0] inverse_row;
  logic             singular;
  logic             last_row;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor state
  logic [ROW_W-1:0] work_m [MAX_SIZE];
  logic [ROW_W-1:0] inv_m  [MAX_SIZE];
  int unsigned      loaded = 0;
  logic [CFG_W-1:0] size_cfg = CFG_W'(16);
  inv_beat_t        inv_rows_due [$];

  int unsigned      fail_cnt = 0;
  int unsigned      rows_sent = 0;
  bit               quiet = 1'b0;
  int unsigned      hold_req = 0;
  int unsigned      stall_left = 0;
  int unsigned      stall_roll;
  inv_beat_t        exp_b;

  gf2_matrix_inverse_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .row_bits    (row_bits),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .inverse_row (inverse_row),
    .singular    (singular),
    .last_row    (last_row),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned active_size();
    if (size_cfg == '0) begin
      return 1;
    end
    if (size_cfg > CFG_W'(MAX_SIZE)) begin
      return MAX_SIZE;
    end
    return int'(size_cfg);
  endfunction

  function automatic logic [ROW_W-1:0] low_bits(input int unsigned n);
    if (n >= ROW_W) begin
      return '1;
    end
    return (ROW_W'(1) << n) - ROW_W'(1);
  endfunction

  // Most gaps short, a few long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Takes one row beat; on the last row of a matrix, inverts and queues the results.
  task automatic absorb_row(input logic [ROW_W-1:0] d);
    int unsigned      n;
    int unsigned      r;
    logic [ROW_W-1:0] t;
    bit               ok;
    inv_beat_t        b;
    n = active_size();
    r = loaded;
    if (r >= n) begin
      r = 0;
    end
    work_m[r] = d & low_bits(n);
    inv_m[r]  = ROW_W'(1) << r;
    r++;
    if (r < n) begin
      loaded = r;
      return;
    end
    loaded = 0;
    ok = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (ok) begin
        for (int j = i + 1; j < n; j++) begin
          if (!work_m[i][i] && work_m[j][i]) begin
            t = work_m[i]; work_m[i] = work_m[j]; work_m[j] = t;
            t = inv_m[i];  inv_m[i]  = inv_m[j];  inv_m[j]  = t;
          end else if (work_m[j][i]) begin
            work_m[j] ^= work_m[i];
            inv_m[j]  ^= inv_m[i];
          end
        end
        if (!work_m[i][i]) begin
          ok = 1'b0;
        end else begin
          for (int j = 0; j < i; j++) begin
            if (work_m[j][i]) begin
              work_m[j] ^= work_m[i];
              inv_m[j]  ^= inv_m[i];
            end
          end
        end
      end
    end
    if (!ok) begin
      b.row = '0; b.sing = 1'b1; b.last = 1'b1;
      inv_rows_due.push_back(b);
    end else begin
      for (int k = 0; k < n; k++) begin
        b.row = inv_m[k]; b.sing = 1'b0; b.last = (k == n - 1);
        inv_rows_due.push_back(b);
      end
    end
  endtask

  // Receiver: random stalls, or a long hold when a test asks for one.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 65) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (inv_rows_due.size() == 0) begin
        $error("result beat with nothing expected: inverse_row %0h singular %0b last_row %0b",
               inverse_row, singular, last_row);
        fail_cnt++;
      end else begin
        exp_b = inv_rows_due.pop_front();
        if (inverse_row !== exp_b.row) begin
          $error("inverse_row: expected %0h, actual %0h", exp_b.row, inverse_row);
          fail_cnt++;
        end
        if (singular !== exp_b.sing) begin
          $error("singular: expected %0b, actual %0b", exp_b.sing, singular);
          fail_cnt++;
        end
        if (last_row !== exp_b.last) begin
          $error("last_row: expected %0b, actual %0b", exp_b.last, last_row);
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_row(input logic [ROW_W-1:0] d);
    int unsigned g;
    g = quiet ? 0 : idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    row_bits <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    absorb_row(d);
    rows_sent++;
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (inv_rows_due.size() != 0);
  endtask

  // Size writes happen only with the block idle.
  task automatic write_size(input logic [CFG_W-1:0] v);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    size_cfg = v;
    loaded = 0;
  endtask

  // kind 0: invertible, 1: random, 2: singular by construction
  task automatic send_matrix(input int unsigned n, input int unsigned kind);
    logic [ROW_W-1:0] rows [MAX_SIZE];
    int unsigned      a;
    int unsigned      c;
    logic [ROW_W-1:0] t;
    for (int i = 0; i < n; i++) begin
      rows[i] = (kind == 1) ? ROW_W'($urandom) : ROW_W'(1) << i;
    end
    if (kind != 1 && n > 1) begin
      repeat (4 * n) begin
        a = $urandom_range(0, n - 1);
        c = $urandom_range(0, n - 1);
        if (a != c) begin
          if ($urandom_range(0, 3) == 0) begin
            t = rows[a]; rows[a] = rows[c]; rows[c] = t;
          end else begin
            rows[a] ^= rows[c];
          end
        end
      end
    end
    if (kind == 2) begin
      a = $urandom_range(0, n - 1);
      c = $urandom_range(0, n - 1);
      rows[a] = (a == c || $urandom_range(0, 1) == 0) ? '0 : rows[c];
    end
    for (int i = 0; i < n; i++) begin
      // columns past the size carry junk the block must drop
      send_row((rows[i] & low_bits(n)) | (ROW_W'($urandom) & ~low_bits(n)));
    end
  endtask

  task automatic test_default_size();
    // reversed upper-bidiagonal rows: needs swaps and eliminations
    for (int k = 0; k < MAX_SIZE; k++) begin
      send_row((ROW_W'(1) << (15 - k)) | ((k > 0) ? ROW_W'(1) << (16 - k) : ROW_W'(0)));
    end
  endtask

  task automatic test_tiny_sizes();
    write_size(CFG_W'(0));  // acts as size 1
    send_row(16'hFFFF);
    send_row(16'hFFFE);
    write_size(CFG_W'(2));
    send_row(16'h0002);
    send_row(16'hFFFD);
    send_row(16'h0000);
    send_row(16'h0001);
  endtask

  task automatic test_size_write_restarts();
    write_size(CFG_W'(3));
    send_row(16'hFFFF);
    write_size(CFG_W'(3));  // drops the partial row above
    send_row(16'h0004);
    send_row(16'h0001);
    send_row(16'h0002);
  endtask

  task automatic test_backpressure();
    write_size(CFG_W'(4));
    quiet = 1'b1;
    hold_req = HOLD_CYCLES;
    repeat (4) send_matrix(4, 0);
    wait_results_done();
    quiet = 1'b0;
  endtask

  task automatic test_random_matrices();
    int unsigned      stop_at;
    int unsigned      phase;
    int unsigned      r;
    int unsigned      n;
    int unsigned      kind;
    logic [CFG_W-1:0] v;
    logic [CFG_W-1:0] edge_sizes [5];
    edge_sizes = '{CFG_W'(1), CFG_W'(16), CFG_W'(17), CFG_W'(31), CFG_W'(0)};
    stop_at = rows_sent + RANDOM_ROWS;
    phase = 0;
    while (rows_sent < stop_at) begin
      if (phase < 5) begin
        v = edge_sizes[phase];
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          v = CFG_W'($urandom_range(1, 5));
        end else if (r < 90) begin
          v = CFG_W'($urandom_range(6, 12));
        end else begin
          v = CFG_W'($urandom_range(13, 31));
        end
      end
      phase++;
      write_size(v);
      quiet = ($urandom_range(0, 5) == 0);
      n = active_size();
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 99);
        kind = (r < 70) ? 0 : (r < 92) ? 1 : 2;
        send_matrix(n, kind);
      end
      // occasionally leave a partial matrix for the next size write to drop
      if (n > 1 && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, n - 1)) send_row(ROW_W'($urandom));
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_size();
    test_tiny_sizes();
    test_size_write_restarts();
    test_backpressure();
    test_random_matrices();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("gf2_matrix_inverse_top regression: pass");
    end else begin
      $display("gf2_matrix_inverse_top regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("gf2_matrix_inverse_top regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
src/gf2inv_pkg.sv
src/gf2inv_dp.sv
src/gf2inv_ctrl.sv
src/gf2_matrix_inverse_top.sv
src/gf2inv_checker.sv
verif/tb.sv
